@@ design/vna_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants
// Item layouts, opcodes and normalize unit status for the vertex normal core.
// ----------------------------------------------------------------------------
package vna_pkg;

    // vertex store geometry (power of two, so an index wraps by truncation)
    localparam int VERTEX_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int IDX_W        = 12;
    localparam int POS_W        = 32;
    localparam int NRM_W        = 16;
    localparam int WIDE_W       = 63;

    // command codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TRI   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // input item
    typedef struct packed {
        logic [1:0]              opcode;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [NRM_W-1:0] init_nx;
        logic signed [NRM_W-1:0] init_ny;
        logic signed [NRM_W-1:0] init_nz;
    } t_in;

    // result item
    typedef struct packed {
        logic signed [NRM_W-1:0] res_x;
        logic signed [NRM_W-1:0] res_y;
        logic signed [NRM_W-1:0] res_z;
        logic                    zero_length;
    } t_out;

    // wide signed vector component fed to the normalize unit
    typedef logic signed [WIDE_W-1:0] t_wide;

    // normalize unit status
    typedef struct packed {
        logic done;
        logic zero;
    } t_norm_stat;

endpackage
`default_nettype wire

@@ design/vna_norm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vna_norm: iterative vector normalizer
// Scales a 3-vector to 30 bits, sums squares on one multiplier, takes an
// integer square root one bit pair a cycle and divides one bit a cycle.
// ----------------------------------------------------------------------------
module vna_norm (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire vna_pkg::t_wide                    i_vec [3],
    output logic signed [vna_pkg::NRM_W-1:0]       o_res [3],
    output vna_pkg::t_norm_stat                    o_stat
);

    typedef enum logic [7:0] {
        N_IDLE  = 8'b0000_0001,
        N_SHIFT = 8'b0000_0010,
        N_SQ    = 8'b0000_0100,
        N_SQE   = 8'b0000_1000,
        N_SQRT  = 8'b0001_0000,
        N_DINIT = 8'b0010_0000,
        N_DIV   = 8'b0100_0000,
        N_DONE  = 8'b1000_0000
    } t_nstate;

    t_nstate                          r_state;
    vna_pkg::t_wide                   r_v [3];
    logic [vna_pkg::WIDE_W-1:0]       r_mag [3];
    logic [1:0]                       r_comp;
    logic [3:0]                       r_cnt;
    logic [61:0]                      r_prod;
    logic [61:0]                      r_sum;
    logic [61:0]                      r_rad;
    logic [61:0]                      r_root;
    logic [61:0]                      r_bit;
    logic [47:0]                      r_rem;
    logic [47:0]                      r_dsh;
    logic [13:0]                      r_q;
    logic signed [vna_pkg::NRM_W-1:0] r_res [3];
    logic                             r_zero;

    logic signed [30:0] w_c;
    logic [30:0]        w_cmag;
    logic signed [61:0] w_sq;
    logic               w_big;
    logic               w_allzero;
    logic [61:0]        w_trial;
    logic [31:0]        w_len;
    logic [47:0]        w_num;
    logic [47:0]        w_lim;
    logic               w_qbit;
    logic [14:0]        w_qf;
    logic signed [15:0] w_qs;

    // current component after scaling and its magnitude
    assign w_c       = r_v[r_comp][30:0];
    assign w_cmag    = w_c[30] ? 31'(-w_c) : 31'(w_c);
    assign w_sq      = w_c * w_c;
    assign w_big     = (|r_mag[0][62:30]) | (|r_mag[1][62:30]) | (|r_mag[2][62:30]);
    assign w_allzero = (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0);

    // square root step and division setup
    assign w_trial = r_root + r_bit;
    assign w_len   = (r_root[31:0] == 32'd0) ? 32'd1 : r_root[31:0];
    assign w_num   = {2'b00, w_cmag, 15'd0} + {16'd0, w_len};
    assign w_lim   = {w_len, 16'd0};
    assign w_qbit  = (r_rem >= r_dsh);
    assign w_qf    = {r_q, w_qbit};
    assign w_qs    = w_c[30] ? -$signed({1'b0, w_qf}) : $signed({1'b0, w_qf});

    assign o_res       = r_res;
    assign o_stat.done = (r_state == N_DONE);
    assign o_stat.zero = r_zero;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            unique case (r_state)
                N_IDLE:  if (i_start) r_state <= w_allzero ? N_DONE : N_SHIFT;
                N_SHIFT: if (!w_big) r_state <= N_SQ;
                N_SQ:    if (r_comp == 2'd2) r_state <= N_SQE;
                N_SQE:   r_state <= N_SQRT;
                N_SQRT:  if (r_bit[0]) r_state <= N_DINIT;
                N_DINIT: begin
                    if (w_num >= w_lim) begin
                        r_state <= (r_comp == 2'd2) ? N_DONE : N_DINIT;
                    end else begin
                        r_state <= N_DIV;
                    end
                end
                N_DIV: begin
                    if (r_cnt == 4'd14) r_state <= (r_comp == 2'd2) ? N_DONE : N_DINIT;
                end
                N_DONE:  r_state <= N_IDLE;
                default: r_state <= N_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_v[i]   <= i_vec[i];
                        r_mag[i] <= i_vec[i][62] ? 63'(-i_vec[i]) : 63'(i_vec[i]);
                        r_res[i] <= '0;
                    end
                    r_zero <= w_allzero;
                    r_comp <= 2'd0;
                    r_prod <= '0;
                    r_sum  <= '0;
                end
            end
            N_SHIFT: begin
                if (w_big) begin
                    for (int i = 0; i < 3; i++) begin
                        r_v[i]   <= r_v[i] >>> 1;
                        r_mag[i] <= r_mag[i] >> 1;
                    end
                end
            end
            N_SQ: begin
                r_prod <= 62'(w_sq);
                r_sum  <= r_sum + r_prod;
                r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
            end
            N_SQE: begin
                r_rad  <= r_sum + r_prod;
                r_root <= '0;
                r_bit  <= 62'd1 << 60;
            end
            N_SQRT: begin
                if (r_rad >= w_trial) begin
                    r_rad  <= r_rad - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            N_DINIT: begin
                if (w_num >= w_lim) begin
                    r_res[r_comp] <= w_c[30] ? -16'sd32767 : 16'sd32767;
                    r_comp        <= r_comp + 2'd1;
                end else begin
                    r_rem <= w_num;
                    r_dsh <= {1'b0, w_len, 15'd0};
                    r_q   <= '0;
                    r_cnt <= '0;
                end
            end
            N_DIV: begin
                if (w_qbit) r_rem <= r_rem - r_dsh;
                r_dsh <= r_dsh >> 1;
                r_q   <= w_qf[13:0];
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd14) begin
                    r_res[r_comp] <= w_qs;
                    r_comp        <= r_comp + 2'd1;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ design/vertex_normal_accumulator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_core: smoothed vertex normal accumulator
// Vertex store plus a sequencer that builds face normals and folds them
// into the corner normals through one shared normalize unit.
// ----------------------------------------------------------------------------
// One item is taken at a time; the input stalls until its result has been
// placed in the output register, and the next item may enter while that
// result still waits. A triangle goes through transfer and position fetch,
// edge scaling and the cross product on one 31x31 multiplier, then one pass
// of the normalize unit for the face and one for each distinct corner (each
// after a corner check and normal fetch; write-back happens as the pass
// ends), and a finish step. A normalize pass shifts a vector wider than 30
// bits right until it fits, then runs a bit-serial square root (31 steps)
// and up to three 15-step restoring divides. Indexes wrap modulo the store
// depth; normals of unwritten vertices are undefined.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire vna_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output vna_pkg::t_out       o_out_data
);

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_PA    = 17'h00002,
        S_PB    = 17'h00004,
        S_PC    = 17'h00008,
        S_DIFF  = 17'h00010,
        S_SCALE = 17'h00020,
        S_MUL   = 17'h00040,
        S_ACC   = 17'h00080,
        S_FNORM = 17'h00100,
        S_FWAIT = 17'h00200,
        S_CCHK  = 17'h00400,
        S_CRD   = 17'h00800,
        S_CSUM  = 17'h01000,
        S_CWAIT = 17'h02000,
        S_READ  = 17'h04000,
        S_RDAT  = 17'h08000,
        S_FIN   = 17'h10000
    } t_state;

    localparam int AW = vna_pkg::ADDR_W;
    localparam int NW = vna_pkg::NRM_W;

    t_state                  r_state;
    vna_pkg::t_in            r_item;
    logic [95:0]             r_pos_mem [vna_pkg::VERTEX_DEPTH];
    logic [47:0]             r_nrm_mem [vna_pkg::VERTEX_DEPTH];
    logic [95:0]             r_pos_rd;
    logic [47:0]             r_nrm_rd;
    logic [95:0]             r_pa;
    logic signed [32:0]      r_d [6];
    logic signed [30:0]      r_ds [6];
    logic [2:0]              r_step;
    logic signed [61:0]      r_prod;
    vna_pkg::t_wide          r_acc;
    vna_pkg::t_wide          r_cr [3];
    logic signed [NW-1:0]    r_face [3];
    logic signed [NW-1:0]    r_res [3];
    logic                    r_zero;
    logic [1:0]              r_ci;
    logic                    r_out_valid;
    vna_pkg::t_out           r_out;

    logic                    w_accept;
    logic [AW-1:0]           w_ia, w_ib, w_ic, w_iv, w_raddr;
    logic                    w_dup;
    logic [1:0]              w_mult;
    logic                    w_fit0, w_fit1;
    logic signed [30:0]      w_opa, w_opb;
    logic signed [61:0]      w_mul;
    logic signed [NW-1:0]    w_nrd [3];
    logic signed [18:0]      w_f19 [3];
    logic signed [18:0]      w_add [3];
    vna_pkg::t_wide          w_nvec [3];
    logic                    w_nstart;
    logic signed [NW-1:0]    w_nres [3];
    vna_pkg::t_norm_stat     w_nstat;
    logic                    w_pos_we, w_nrm_we;
    logic [AW-1:0]           w_waddr;
    logic [47:0]             w_nrm_wdata;
    logic                    w_out_free;

    // handshake
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // corner indexes of the held item
    assign w_ia = r_item.index_a[AW-1:0];
    assign w_ib = r_item.index_b[AW-1:0];
    assign w_ic = r_item.index_c[AW-1:0];
    assign w_iv = (r_ci == 2'd0) ? w_ia : (r_ci == 2'd1) ? w_ib : w_ic;
    assign w_dup = ((r_ci == 2'd1) && (w_ib == w_ia)) ||
                   ((r_ci == 2'd2) && ((w_ic == w_ia) || (w_ic == w_ib)));
    assign w_mult = 2'(w_ia == w_iv) + 2'(w_ib == w_iv) + 2'(w_ic == w_iv);

    // store read address
    always_comb begin
        unique case (r_state)
            S_PB:    w_raddr = w_ib;
            S_PC:    w_raddr = w_ic;
            S_CRD:   w_raddr = w_iv;
            default: w_raddr = w_ia;
        endcase
    end

    // store writes: vertex write on transfer, corner write-back after normalize
    assign w_pos_we    = w_accept && (i_in_data.opcode == vna_pkg::OP_WRITE);
    assign w_nrm_we    = w_pos_we || ((r_state == S_CWAIT) && w_nstat.done);
    assign w_waddr     = (r_state == S_IDLE) ? i_in_data.index_a[AW-1:0] : w_iv;
    assign w_nrm_wdata = (r_state == S_IDLE) ?
                         {i_in_data.init_nx, i_in_data.init_ny, i_in_data.init_nz} :
                         {w_nres[0], w_nres[1], w_nres[2]};

    // vertex store
    always_ff @(posedge i_clk) begin
        if (w_pos_we) begin
            r_pos_mem[w_waddr] <= {i_in_data.pos_x, i_in_data.pos_y, i_in_data.pos_z};
        end
        r_pos_rd <= r_pos_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_nrm_we) r_nrm_mem[w_waddr] <= w_nrm_wdata;
        r_nrm_rd <= r_nrm_mem[w_raddr];
    end

    // edge vector scale: fewest right shifts that bring all into 31 bits
    always_comb begin
        w_fit0 = 1'b1;
        w_fit1 = 1'b1;
        for (int i = 0; i < 6; i++) begin
            if (!((r_d[i][32:30] == 3'b000) || (r_d[i][32:30] == 3'b111))) w_fit0 = 1'b0;
            if (r_d[i][32] != r_d[i][31]) w_fit1 = 1'b0;
        end
    end

    // cross product operand select, one product per step
    always_comb begin
        case (r_step)
            3'd0:    begin w_opa = r_ds[1]; w_opb = r_ds[5]; end
            3'd1:    begin w_opa = r_ds[2]; w_opb = r_ds[4]; end
            3'd2:    begin w_opa = r_ds[2]; w_opb = r_ds[3]; end
            3'd3:    begin w_opa = r_ds[0]; w_opb = r_ds[5]; end
            3'd4:    begin w_opa = r_ds[0]; w_opb = r_ds[4]; end
            3'd5:    begin w_opa = r_ds[1]; w_opb = r_ds[3]; end
            default: begin w_opa = '0;      w_opb = '0;      end
        endcase
    end
    assign w_mul = w_opa * w_opb;

    // corner sum: stored normal plus multiplicity times face normal
    assign w_nrd[0] = r_nrm_rd[47:32];
    assign w_nrd[1] = r_nrm_rd[31:16];
    assign w_nrd[2] = r_nrm_rd[15:0];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_f19[i] = 19'(r_face[i]);
            case (w_mult)
                2'd1:    w_add[i] = w_f19[i];
                2'd2:    w_add[i] = w_f19[i] <<< 1;
                default: w_add[i] = w_f19[i] + (w_f19[i] <<< 1);
            endcase
            w_nvec[i] = (r_state == S_FNORM) ? r_cr[i] :
                        vna_pkg::t_wide'(19'(w_nrd[i]) + w_add[i]);
        end
    end
    assign w_nstart = (r_state == S_FNORM) || (r_state == S_CSUM);

    vna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_nstart),
        .i_vec   (w_nvec),
        .o_res   (w_nres),
        .o_stat  (w_nstat)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // result register: load on finish, clear once taken
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in_data.opcode)
                            vna_pkg::OP_TRI:  r_state <= S_PA;
                            vna_pkg::OP_READ: r_state <= S_READ;
                            default:          r_state <= S_FIN;
                        endcase
                    end
                end
                S_PA:    r_state <= S_PB;
                S_PB:    r_state <= S_PC;
                S_PC:    r_state <= S_DIFF;
                S_DIFF:  r_state <= S_SCALE;
                S_SCALE: r_state <= S_MUL;
                S_MUL:   r_state <= S_ACC;
                S_ACC:   r_state <= (r_step == 3'd5) ? S_FNORM : S_MUL;
                S_FNORM: r_state <= S_FWAIT;
                S_FWAIT: if (w_nstat.done) r_state <= S_CCHK;
                S_CCHK: begin
                    if (r_ci == 2'd3)  r_state <= S_FIN;
                    else if (!w_dup)   r_state <= S_CRD;
                end
                S_CRD:   r_state <= S_CSUM;
                S_CSUM:  r_state <= S_CWAIT;
                S_CWAIT: if (w_nstat.done) r_state <= S_CCHK;
                S_READ:  r_state <= S_RDAT;
                S_RDAT:  r_state <= S_FIN;
                S_FIN:   if (w_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_item <= i_in_data;
                    r_zero <= 1'b0;
                    for (int i = 0; i < 3; i++) r_res[i] <= '0;
                end
            end
            S_PB: r_pa <= r_pos_rd;
            S_PC: begin
                r_d[0] <= 33'(signed'(r_pos_rd[95:64])) - 33'(signed'(r_pa[95:64]));
                r_d[1] <= 33'(signed'(r_pos_rd[63:32])) - 33'(signed'(r_pa[63:32]));
                r_d[2] <= 33'(signed'(r_pos_rd[31:0]))  - 33'(signed'(r_pa[31:0]));
            end
            S_DIFF: begin
                r_d[3] <= 33'(signed'(r_pos_rd[95:64])) - 33'(signed'(r_pa[95:64]));
                r_d[4] <= 33'(signed'(r_pos_rd[63:32])) - 33'(signed'(r_pa[63:32]));
                r_d[5] <= 33'(signed'(r_pos_rd[31:0]))  - 33'(signed'(r_pa[31:0]));
            end
            S_SCALE: begin
                for (int i = 0; i < 6; i++) begin
                    r_ds[i] <= w_fit0 ? r_d[i][30:0] : w_fit1 ? r_d[i][31:1] : r_d[i][32:2];
                end
                r_step <= 3'd0;
            end
            S_MUL: r_prod <= w_mul;
            S_ACC: begin
                if (!r_step[0]) r_acc <= vna_pkg::t_wide'(r_prod);
                else            r_cr[r_step[2:1]] <= r_acc - vna_pkg::t_wide'(r_prod);
                r_step <= r_step + 3'd1;
            end
            S_FWAIT: begin
                if (w_nstat.done) begin
                    r_face <= w_nres;
                    r_res  <= w_nres;
                    r_zero <= w_nstat.zero;
                    r_ci   <= 2'd0;
                end
            end
            S_CCHK: if ((r_ci != 2'd3) && w_dup) r_ci <= r_ci + 2'd1;
            S_CWAIT: begin
                if (w_nstat.done) begin
                    r_zero <= r_zero | w_nstat.zero;
                    r_ci   <= r_ci + 2'd1;
                end
            end
            S_RDAT: r_res <= w_nrd;
            S_FIN: begin
                if (w_out_free) begin
                    r_out.res_x       <= r_res[0];
                    r_out.res_y       <= r_res[1];
                    r_out.res_z       <= r_res[2];
                    r_out.zero_length <= r_zero;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
